FILE: hdl/midpoint_circle_outline_core_defines.svh
// ---------------------------------------------------------------------------
// Midpoint circle outline core: assertion macros
// Shared property shapes for the checkers of this block. Each macro expects
// signals named clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_OUTLINE_CORE_DEFINES_SVH
`define MIDPOINT_CIRCLE_OUTLINE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mcoc_pkg.sv
// ---------------------------------------------------------------------------
// Midpoint circle outline package
// Request codes, point sequencing type and decision constants.
// ---------------------------------------------------------------------------
`default_nettype none

package mcoc_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef logic [2:0] point_idx_t;

  localparam point_idx_t FIRST_POINT = 3'd0;
  localparam point_idx_t LAST_POINT  = 3'd7;

  localparam int DEC_START     = 3;
  localparam int DEC_DIAG_ADD  = 10;
  localparam int DEC_RIGHT_ADD = 6;

endpackage

`default_nettype wire

FILE: hdl/midpoint_circle_outline_core.sv
// ---------------------------------------------------------------------------
// Midpoint circle outline core
// Bresenham midpoint circle rasterizer producing eight mirrored points per step.
// ---------------------------------------------------------------------------
// A start request (func = 0) loads center, radius and color when accepted and
// produces no points. A step request (func = 1) advances the circle by one
// octant step in the cycle it is accepted and then emits its eight mirrored
// points through the output register, one per cycle while out_ready is high.
// The next request is accepted in the same cycle as the eighth point of the
// current step moves into the single point output register. The final point of
// the circle carries circle_done, after which steps are accepted and ignored
// until the next start.
`default_nettype none

module midpoint_circle_outline_core #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          func,
  input  wire logic signed [COORD_BITS-1:0]  center_x,
  input  wire logic signed [COORD_BITS-1:0]  center_y,
  input  wire logic        [RADIUS_BITS-1:0] radius,
  input  wire logic        [31:0]            pen_color,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [COORD_BITS:0]    point_x,
  output logic signed      [COORD_BITS:0]    point_y,
  output logic             [31:0]            point_color,
  output logic                               last_of_step,
  output logic                               circle_done
);

  localparam int OFF_W = RADIUS_BITS + 1;
  localparam int DEC_W = RADIUS_BITS + 6;
  localparam int PT_W  = COORD_BITS + 1;
  localparam int SUM_W = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 2;

  logic                         active;
  logic        [COORD_BITS-1:0] mid_x;
  logic        [COORD_BITS-1:0] mid_y;
  logic        [31:0]           ink;
  logic        [OFF_W-1:0]      off_x;
  logic        [OFF_W-1:0]      off_y;
  logic        [DEC_W-1:0]      decision;
  logic                         busy;
  logic                         step_done;
  mcoc_pkg::point_idx_t         idx;

  logic                         in_accept;
  logic                         step_go;
  logic                         load_out;
  logic                         last_load;
  logic        [OFF_W-1:0]      off_x_next;
  logic        [OFF_W-1:0]      off_y_next;
  logic        [DEC_W-1:0]      decision_next;
  logic        [DEC_W-1:0]      dec_init;
  logic        [OFF_W-1:0]      a_off;
  logic        [OFF_W-1:0]      b_off;
  logic                         neg_a;
  logic                         neg_b;
  logic        [SUM_W-1:0]      cx_ext;
  logic        [SUM_W-1:0]      cy_ext;
  logic        [SUM_W-1:0]      a_ext;
  logic        [SUM_W-1:0]      b_ext;
  logic        [SUM_W-1:0]      px_sum;
  logic        [SUM_W-1:0]      py_sum;

  assign load_out  = busy && (!out_valid || out_ready);
  assign last_load = load_out && (idx == mcoc_pkg::LAST_POINT);
  assign in_ready  = !busy || last_load;
  assign in_accept = in_valid && in_ready;
  assign step_go   = in_accept && (func == mcoc_pkg::FUNC_STEP) && active;

  assign dec_init = DEC_W'(mcoc_pkg::DEC_START)
                  - {{(DEC_W-RADIUS_BITS-1){1'b0}}, radius, 1'b0};

  always_comb begin
    off_x_next = off_x + OFF_W'(1);
    if (!decision[DEC_W-1]) begin
      off_y_next    = off_y - OFF_W'(1);
      decision_next = decision
                    + {{(DEC_W-OFF_W-2){1'b0}}, off_x, 2'b00}
                    - {{(DEC_W-OFF_W-2){1'b0}}, off_y, 2'b00}
                    + DEC_W'(mcoc_pkg::DEC_DIAG_ADD);
    end else begin
      off_y_next    = off_y;
      decision_next = decision
                    + {{(DEC_W-OFF_W-2){1'b0}}, off_x, 2'b00}
                    + DEC_W'(mcoc_pkg::DEC_RIGHT_ADD);
    end
  end

  // Points 0-3 mirror (x, y), points 4-7 mirror the swapped pair (y, x).
  always_comb begin
    a_off  = idx[2] ? off_y : off_x;
    b_off  = idx[2] ? off_x : off_y;
    neg_a  = idx[0] ^ idx[1];
    neg_b  = idx[1];
    cx_ext = {{(SUM_W-COORD_BITS){mid_x[COORD_BITS-1]}}, mid_x};
    cy_ext = {{(SUM_W-COORD_BITS){mid_y[COORD_BITS-1]}}, mid_y};
    a_ext  = {{(SUM_W-OFF_W){1'b0}}, a_off};
    b_ext  = {{(SUM_W-OFF_W){1'b0}}, b_off};
    px_sum = neg_a ? (cx_ext - a_ext) : (cx_ext + a_ext);
    py_sum = neg_b ? (cy_ext - b_ext) : (cy_ext + b_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      mid_x     <= '0;
      mid_y     <= '0;
      ink       <= '0;
      off_x     <= '0;
      off_y     <= '0;
      decision  <= '0;
      busy      <= 1'b0;
      step_done <= 1'b0;
      idx       <= mcoc_pkg::FIRST_POINT;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (step_go) begin
        busy <= 1'b1;
      end else if (last_load) begin
        busy <= 1'b0;
      end

      if (load_out && (idx != mcoc_pkg::LAST_POINT)) begin
        idx <= idx + 3'd1;
      end

      if (in_accept) begin
        if (func == mcoc_pkg::FUNC_START) begin
          mid_x    <= center_x;
          mid_y    <= center_y;
          ink      <= pen_color;
          off_x    <= '0;
          off_y    <= {1'b0, radius};
          decision <= dec_init;
          active   <= (radius != '0);
        end else if (active) begin
          off_x     <= off_x_next;
          off_y     <= off_y_next;
          decision  <= decision_next;
          step_done <= !(off_x_next < off_y_next);
          active    <= (off_x_next < off_y_next);
          idx       <= mcoc_pkg::FIRST_POINT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      point_x      <= px_sum[PT_W-1:0];
      point_y      <= py_sum[PT_W-1:0];
      point_color  <= ink;
      last_of_step <= (idx == mcoc_pkg::LAST_POINT);
      circle_done  <= (idx == mcoc_pkg::LAST_POINT) && step_done;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcoc_checker.sv
// ---------------------------------------------------------------------------
// Midpoint circle outline checker
// Port-level checks of point sequencing, completion flags and output holding.
// ---------------------------------------------------------------------------
`default_nettype none

`include "midpoint_circle_outline_core_defines.svh"

module mcoc_checker #(
  parameter int COORD_BITS  = 12
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [COORD_BITS:0]    point_x,
  input wire logic signed [COORD_BITS:0]    point_y,
  input wire logic        [31:0]            point_color,
  input wire logic                          last_of_step,
  input wire logic                          circle_done
);

  mcoc_pkg::point_idx_t pos;

  // Position of the waiting point within its step, counted from delivered points.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= mcoc_pkg::FIRST_POINT;
    end else if (out_valid && out_ready) begin
      pos <= pos + 3'd1;
    end
  end

  `MCOC_ASSERT_NOW(a_done_on_last, out_valid && circle_done, last_of_step,
    "circle_done without last_of_step")

  `MCOC_ASSERT_NOW(a_last_every_eighth, out_valid,
    last_of_step == (pos == mcoc_pkg::LAST_POINT),
    "last_of_step not on the eighth point of a step")

  `MCOC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(point_x) && $stable(point_y) && $stable(point_color),
    "stalled point changed")

  `MCOC_ASSERT_NEXT(a_color_within_step, out_valid && out_ready && !last_of_step,
    $stable(point_color), "color changed within a step")

endmodule

bind midpoint_circle_outline_core mcoc_checker #(
  .COORD_BITS(COORD_BITS)
) u_mcoc_checker (.*);

`default_nettype wire
